// ===== rtl/core/swt_pkg.sv =====
// shared types and constants for the session timeout wheel
// no dependencies; used by swt_cfg, swt_ram users and the top level
`default_nettype none

package swt_pkg;

    localparam int SLOTS_DEFAULT = 64;

    localparam int KIND_W   = 2;
    localparam int ID_W     = 16;
    localparam int STAMP_W  = 32;
    localparam int CNT_W    = 7;
    localparam int STATUS_W = 2;
    localparam int TMO_W    = 6;

    // slot word: valid, id, stamp
    localparam int WORD_W   = 1 + ID_W + STAMP_W;

    localparam int OUT_W    = 32;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 6'd30;

    // register index of timeout_ticks
    localparam logic [APB_AW-3:0] REG_TIMEOUT = 1'b0;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TOUCH  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ID    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/session_timeout_wheel_core.sv =====
// session timeout wheel top level: sequencer, slot ram scan and result register
// depends on swt_pkg, swt_ram and swt_cfg
`default_nettype none

// Single-level timing wheel of SLOTS slots, one session per slot, kept in one
// slot ram (valid, id, stamp) with one read port and one comparator. After
// reset the block clears every slot of the ram and takes no word meanwhile;
// register writes are taken at any time. A tick word goes from accept through
// a ram read of the pointer slot and a check to the result load. A non-tick
// word with id 0 goes from accept straight to the result load. Add, touch and
// remove scan every slot through the ram read port, one slot a cycle, after
// one compare and subtract step for each wrap of the target slot past the end
// of the wheel (at most one for SLOTS >= 64, at most (SLOTS + 62) / SLOTS
// rounded down below that); a rejected word then goes to the result load, an
// add that places takes a place step, a remove a vacate step, a touch both.
// A full output register stalls the result load. One word is in work at a
// time; the result sits in an output register as the next word is accepted.
module session_timeout_wheel_core #(
    parameter int SLOTS = swt_pkg::SLOTS_DEFAULT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input words
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [swt_pkg::ID_W-1:0]     s_axis_tdata,  // [15:0] conn_id
    input  wire logic [swt_pkg::KIND_W-1:0]   s_axis_tuser,  // [1:0] kind
    // result words
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [1:0] status, [2] evicted, [3] expired, [19:4] expired_id,
    // [26:20] live_sessions, [31:27] zero
    output logic      [swt_pkg::OUT_W-1:0]    m_axis_tdata,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [swt_pkg::APB_AW-1:0]   paddr,
    input  wire logic [swt_pkg::APB_DW-1:0]   pwdata,
    output logic      [swt_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    // pointer + timeout before wrapping
    localparam int TW = ((AW > swt_pkg::TMO_W) ? AW : swt_pkg::TMO_W) + 1;
    localparam int PAD_W = swt_pkg::OUT_W - (swt_pkg::STATUS_W + 2 + swt_pkg::ID_W
                                             + swt_pkg::CNT_W);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRAP,
        ST_SCAN,
        ST_DECIDE,
        ST_VACATE,
        ST_PLACE,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_DONE
    } t_state;

    t_state                         r_state, n_state;
    logic [CW-1:0]                  r_cnt, n_cnt;
    logic [AW-1:0]                  r_ptr, n_ptr;
    logic [swt_pkg::CNT_W-1:0]      r_total, n_total;
    logic [swt_pkg::STAMP_W-1:0]    r_clock, n_clock;
    logic [swt_pkg::KIND_W-1:0]     r_kind, n_kind;
    logic [swt_pkg::ID_W-1:0]       r_id, n_id;
    logic [TW-1:0]                  r_sum, n_sum;
    logic                           r_rd_pend, n_rd_pend;
    logic [AW-1:0]                  r_rd_idx, n_rd_idx;
    logic                           r_found, n_found;
    logic [AW-1:0]                  r_fidx, n_fidx;
    logic                           r_tgt_valid, n_tgt_valid;
    logic [swt_pkg::STATUS_W-1:0]   r_status, n_status;
    logic                           r_evicted, n_evicted;
    logic                           r_expired, n_expired;
    logic [swt_pkg::ID_W-1:0]       r_exp_id, n_exp_id;
    logic                           r_m_valid, n_m_valid;
    logic [swt_pkg::OUT_W-1:0]      r_m_data, n_m_data;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [swt_pkg::WORD_W-1:0]     ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [swt_pkg::WORD_W-1:0]     ram_rdata;

    logic                           rd_valid;
    logic [swt_pkg::ID_W-1:0]       rd_id;
    logic [swt_pkg::STAMP_W-1:0]    rd_stamp;
    logic [swt_pkg::STAMP_W-1:0]    idle_ticks;
    logic [AW-1:0]                  tgt;
    logic                           ev;
    logic [swt_pkg::TMO_W-1:0]      timeout;

    swt_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_timeout (timeout)
    );

    swt_ram #(
        .WIDTH (swt_pkg::WORD_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_valid   = ram_rdata[swt_pkg::WORD_W-1];
    assign rd_id      = ram_rdata[swt_pkg::STAMP_W +: swt_pkg::ID_W];
    assign rd_stamp   = ram_rdata[swt_pkg::STAMP_W-1:0];
    assign idle_ticks = r_clock - rd_stamp;
    assign tgt        = r_sum[AW-1:0];
    // a touch that already sits in its target slot vacates it first
    assign ev         = r_tgt_valid && !((r_kind == swt_pkg::KIND_TOUCH) && (r_fidx == tgt));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_total     = r_total;
        n_clock     = r_clock;
        n_kind      = r_kind;
        n_id        = r_id;
        n_sum       = r_sum;
        n_rd_pend   = r_rd_pend;
        n_rd_idx    = r_rd_idx;
        n_found     = r_found;
        n_fidx      = r_fidx;
        n_tgt_valid = r_tgt_valid;
        n_status    = r_status;
        n_evicted   = r_evicted;
        n_expired   = r_expired;
        n_exp_id    = r_exp_id;
        n_m_valid   = r_m_valid;
        n_m_data    = r_m_data;
        ram_we      = 1'b0;
        ram_waddr   = r_cnt[AW-1:0];
        ram_wdata   = '0;
        ram_raddr   = r_cnt[AW-1:0];

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CW'(SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind    = s_axis_tuser;
                    n_id      = s_axis_tdata;
                    n_status  = swt_pkg::STATUS_OK;
                    n_evicted = 1'b0;
                    n_expired = 1'b0;
                    n_exp_id  = '0;
                    n_found   = 1'b0;
                    n_tgt_valid = 1'b0;
                    n_sum     = TW'(r_ptr) + TW'(timeout);
                    if (s_axis_tuser == swt_pkg::KIND_TICK) begin
                        n_state = ST_TICK_RD;
                    end else if (s_axis_tdata == '0) begin
                        n_status = swt_pkg::STATUS_BAD_ID;
                        n_state  = ST_DONE;
                    end else begin
                        n_state = ST_WRAP;
                    end
                end
            end
            ST_WRAP: begin
                // one compare and subtract a cycle
                if (r_sum >= TW'(SLOTS)) begin
                    n_sum = r_sum - TW'(SLOTS);
                end else begin
                    n_cnt     = '0;
                    n_rd_pend = 1'b0;
                    n_state   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_pend) begin
                    if (rd_valid && (rd_id == r_id) && !r_found) begin
                        n_found = 1'b1;
                        n_fidx  = r_rd_idx;
                    end
                    if (r_rd_idx == tgt) begin
                        n_tgt_valid = rd_valid;
                    end
                end
                if (r_cnt == CW'(SLOTS)) begin
                    n_rd_pend = 1'b0;
                    n_state   = ST_DECIDE;
                end else begin
                    n_rd_pend = 1'b1;
                    n_rd_idx  = r_cnt[AW-1:0];
                    n_cnt     = r_cnt + 1'b1;
                end
            end
            ST_DECIDE: begin
                if (r_kind == swt_pkg::KIND_ADD) begin
                    if (r_found) begin
                        n_status = swt_pkg::STATUS_DUPLICATE;
                        n_state  = ST_DONE;
                    end else begin
                        n_state = ST_PLACE;
                    end
                end else if (!r_found) begin
                    n_status = swt_pkg::STATUS_NOT_FOUND;
                    n_state  = ST_DONE;
                end else begin
                    n_state = ST_VACATE;
                end
            end
            ST_VACATE: begin
                ram_we    = 1'b1;
                ram_waddr = r_fidx;
                if (r_kind == swt_pkg::KIND_TOUCH) begin
                    n_state = ST_PLACE;
                end else begin
                    n_total = r_total - 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = tgt;
                ram_wdata = {1'b1, r_id, r_clock};
                n_evicted = ev;
                if (r_kind == swt_pkg::KIND_ADD) begin
                    n_total = r_total - swt_pkg::CNT_W'(ev) + 1'b1;
                end else begin
                    n_total = r_total - swt_pkg::CNT_W'(ev);
                end
                n_state = ST_DONE;
            end
            ST_TICK_RD: begin
                ram_raddr = r_ptr;
                n_state   = ST_TICK_CHK;
            end
            ST_TICK_CHK: begin
                ram_waddr = r_ptr;
                if (rd_valid && (idle_ticks >= swt_pkg::STAMP_W'(timeout))) begin
                    ram_we    = 1'b1;
                    n_expired = 1'b1;
                    n_exp_id  = rd_id;
                    n_total   = r_total - 1'b1;
                end
                n_ptr   = (r_ptr == AW'(SLOTS - 1)) ? '0 : r_ptr + 1'b1;
                n_clock = r_clock + 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {{PAD_W{1'b0}}, r_total, r_exp_id, r_expired, r_evicted,
                                 r_status};
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_ptr     <= '0;
            r_total   <= '0;
            r_clock   <= '0;
            r_rd_pend <= 1'b0;
            r_found   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_ptr     <= n_ptr;
            r_total   <= n_total;
            r_clock   <= n_clock;
            r_rd_pend <= n_rd_pend;
            r_found   <= n_found;
            r_m_valid <= n_m_valid;
        end
        r_kind      <= n_kind;
        r_id        <= n_id;
        r_sum       <= n_sum;
        r_rd_idx    <= n_rd_idx;
        r_fidx      <= n_fidx;
        r_tgt_valid <= n_tgt_valid;
        r_status    <= n_status;
        r_evicted   <= n_evicted;
        r_expired   <= n_expired;
        r_exp_id    <= n_exp_id;
        r_m_data    <= n_m_data;
    end

    // session count cannot exceed the wheel unless the count wraps
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SLOTS > 127) || (r_total <= swt_pkg::CNT_W'(SLOTS)))
        else $error("session count above slot count");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= AW'(SLOTS - 1))
        else $error("wheel pointer out of range");

    a_tick_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK_CHK) |=> (r_clock == $past(r_clock) + 1'b1))
        else $error("tick did not advance the tick clock");

    a_add_no_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PLACE && r_kind == swt_pkg::KIND_ADD) |-> !r_found)
        else $error("add placed an id that is already present");

endmodule

`default_nettype wire

// ===== rtl/core/swt_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module swt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/swt_cfg.sv =====
// apb register block holding timeout_ticks
// depends on swt_pkg
`default_nettype none

module swt_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [swt_pkg::APB_AW-1:0]  paddr,
    input  wire logic [swt_pkg::APB_DW-1:0]  pwdata,
    output logic      [swt_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output logic      [swt_pkg::TMO_W-1:0]   o_timeout
);

    logic [swt_pkg::TMO_W-1:0] r_timeout;
    logic                      sel_timeout;

    // register index sits above the byte offset
    assign sel_timeout = (paddr[swt_pkg::APB_AW-1:2] == swt_pkg::REG_TIMEOUT);
    assign pready      = 1'b1;
    assign o_timeout   = r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= swt_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && sel_timeout) begin
            r_timeout <= pwdata[swt_pkg::TMO_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_timeout) begin
            prdata = {{(swt_pkg::APB_DW - swt_pkg::TMO_W){1'b0}}, r_timeout};
        end
    end

endmodule

`default_nettype wire
